>>> src/pmm_pkg.sv
package pmm_pkg;

    // Transaction kinds carried in tuser on the input side.
    typedef enum logic [1:0] {
        KIND_WR_7FFD = 2'd0,
        KIND_WR_1FFD = 2'd1,
        KIND_MEM_RD  = 2'd2,
        KIND_EXT_RD  = 2'd3
    } kind_t;

    localparam logic [15:0] LAYER_ADDR_MASK  = 16'hFFF3;
    localparam logic [15:0] LAYER_ADDR_MATCH = 16'h0100;
    localparam int unsigned LOCK_BIT         = 5;
    localparam int unsigned PAGING_BIT       = 1;
    localparam int unsigned RAM0_BIT         = 0;
    localparam int unsigned ROMSEL_BIT       = 4;
    localparam logic [7:0]  READBACK_IDLE    = 8'hFF;
    localparam logic [2:0]  SCREEN_NORMAL    = 3'd5;
    localparam logic [2:0]  SCREEN_SHADOW    = 3'd7;

    typedef struct packed {
        logic        dos_active;
        logic        opcode_fetch;
        logic [7:0]  port_value;
        logic [15:0] address;
        kind_t       kind;
    } item_t;

    typedef struct packed {
        logic [7:0] readback;
        logic [1:0] rom_layer;
        logic [2:0] screen_page;
        logic [5:0] slot3_ram_page;
        logic [3:0] slot0_rom_page;
        logic       slot0_is_ram;
    } result_t;

    // Next ROM layer: row is address bits 3..2, column the current layer.
    function automatic logic [1:0] layer_step(input logic [1:0] row, input logic [1:0] col);
        logic [1:0] nxt;
        unique case ({row, col})
            4'h0: nxt = 2'd0;
            4'h1: nxt = 2'd1;
            4'h2: nxt = 2'd2;
            4'h3: nxt = 2'd3;
            4'h4: nxt = 2'd3;
            4'h5: nxt = 2'd3;
            4'h6: nxt = 2'd3;
            4'h7: nxt = 2'd2;
            4'h8: nxt = 2'd2;
            4'h9: nxt = 2'd2;
            4'hA: nxt = 2'd0;
            4'hB: nxt = 2'd1;
            4'hC: nxt = 2'd1;
            4'hD: nxt = 2'd0;
            4'hE: nxt = 2'd1;
            default: nxt = 2'd0;
        endcase
        return nxt;
    endfunction

endpackage

>>> src/pmm_in_stage.sv
// Input register: holds one accepted transaction until the core takes it.
module pmm_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pmm_pkg::item_t in_item,
    input  logic           advance,
    output logic           st_valid,
    output pmm_pkg::item_t st_item
);

    logic           valid_reg;
    logic           valid_next;
    pmm_pkg::item_t item_reg;

    assign in_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign st_valid = valid_reg;
    assign st_item  = item_reg;

endmodule

>>> src/pmm_core.sv
// Paging state, mapping logic and the result register.
module pmm_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             st_valid,
    input  pmm_pkg::item_t   st_item,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output pmm_pkg::result_t out_result
);

    logic [7:0]       page_a_reg, page_a_next;
    logic [7:0]       page_b_reg, page_b_next;
    logic             rom_sel_reg, rom_sel_next;
    logic [1:0]       layer_reg, layer_next;
    logic             out_valid_reg;
    pmm_pkg::result_t result_reg;
    pmm_pkg::result_t result_next;
    logic             fire;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = st_valid && advance;

    always_comb begin
        page_a_next = page_a_reg;
        page_b_next = page_b_reg;
        rom_sel_next = rom_sel_reg;
        layer_next = layer_reg;
        result_next.readback = pmm_pkg::READBACK_IDLE;
        unique case (st_item.kind)
            pmm_pkg::KIND_WR_7FFD: begin
                if (!page_a_reg[pmm_pkg::LOCK_BIT]) begin
                    page_a_next  = st_item.port_value;
                    rom_sel_next = st_item.port_value[pmm_pkg::ROMSEL_BIT];
                end
            end
            pmm_pkg::KIND_WR_1FFD: begin
                page_b_next = st_item.port_value;
            end
            pmm_pkg::KIND_MEM_RD: begin
                if (page_b_reg[pmm_pkg::PAGING_BIT] && !st_item.opcode_fetch &&
                    ((st_item.address & pmm_pkg::LAYER_ADDR_MASK) ==
                     pmm_pkg::LAYER_ADDR_MATCH)) begin
                    layer_next = pmm_pkg::layer_step(st_item.address[3:2], layer_reg);
                end
            end
            pmm_pkg::KIND_EXT_RD: begin
                if (!st_item.address[0]) begin
                    result_next.readback = {2'b00, rom_sel_reg, page_b_reg[4],
                                            page_a_reg[3:0]};
                end
            end
            default: begin
            end
        endcase

        result_next.slot0_is_ram = page_b_next[pmm_pkg::RAM0_BIT];
        if (page_b_next[pmm_pkg::RAM0_BIT]) begin
            result_next.slot0_rom_page = 4'd0;
        end else if (page_b_next[pmm_pkg::PAGING_BIT]) begin
            result_next.slot0_rom_page = {layer_next, 2'b10};
        end else begin
            result_next.slot0_rom_page = {layer_next, st_item.dos_active, rom_sel_next};
        end
        result_next.slot3_ram_page = {page_b_next[7:6], page_b_next[4], page_a_next[2:0]};
        result_next.screen_page    = page_a_next[3] ? pmm_pkg::SCREEN_SHADOW
                                                    : pmm_pkg::SCREEN_NORMAL;
        result_next.rom_layer      = layer_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_a_reg    <= 8'd0;
            page_b_reg    <= 8'd0;
            rom_sel_reg   <= 1'b0;
            layer_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                page_a_reg  <= page_a_next;
                page_b_reg  <= page_b_next;
                rom_sel_reg <= rom_sel_next;
                layer_reg   <= layer_next;
            end
            if (advance) begin
                out_valid_reg <= st_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

>>> src/paged_memory_mapper_with_rom_layers.sv
// Memory paging unit for an 8-bit home computer with two paging ports (7FFD and
// 1FFD) and a four-layer ROM. Every input transaction, whether a port write, a
// memory read or a sound-chip extension port read, yields exactly one result
// transaction describing the mapping after it has taken effect. A transaction
// passes through an input register and then one stage of mapping logic into the
// result register. The block sustains one transaction per cycle; the input side
// stalls only when the result register is full and the downstream side is not
// taking it.
module paged_memory_mapper_with_rom_layers (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata fields from bit 0: address[15:0], port_value[23:16], opcode_fetch[24],
    // dos_active[25], zero padding[31:26].
    input  logic [31:0] s_tdata,
    // tuser fields from bit 0: kind[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata fields from bit 0: slot0_is_ram[0], slot0_rom_page[4:1],
    // slot3_ram_page[10:5], screen_page[13:11], rom_layer[15:14], readback[23:16].
    output logic [23:0] m_tdata
);

    pmm_pkg::item_t   in_item;
    pmm_pkg::item_t   st_item;
    pmm_pkg::result_t result;
    logic             st_valid;
    logic             advance;

    // Unpack the incoming transaction; padding bits of tdata are ignored.
    always_comb begin
        in_item.kind         = pmm_pkg::kind_t'(s_tuser);
        in_item.address      = s_tdata[15:0];
        in_item.port_value   = s_tdata[23:16];
        in_item.opcode_fetch = s_tdata[24];
        in_item.dos_active   = s_tdata[25];
    end

    pmm_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .advance  (advance),
        .st_valid (st_valid),
        .st_item  (st_item)
    );

    // The core holds the paging registers and the ROM layer, and updates them
    // as each transaction moves into the result register.
    pmm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .st_valid   (st_valid),
        .st_item    (st_item),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = result;

endmodule

>>> src/pmm_checker.sv
// Port-level checks for the paging unit.
module pmm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // No result may appear in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The screen is always page 5 or page 7.
    a_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[13:11] == 3'd5) || (m_tdata[13:11] == 3'd7))
        else $error("bad screen page");

    // RAM at slot 0 reports ROM page zero.
    a_ram_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("ROM page reported while slot 0 maps RAM");

    // The extension readback is either idle or has its top two bits clear.
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:16] == 8'hFF) || (m_tdata[23:22] == 2'b00))
        else $error("malformed readback byte");

endmodule

bind paged_memory_mapper_with_rom_layers pmm_checker u_pmm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the paging unit. Every bus transaction that the
// unit accepts is run through a local model of the paging registers and the
// ROM layer table. The expected mapping is queued in order, and each result
// transaction that leaves the unit is compared with it one field at a time.
// Both stream sides pause at random. There is one long stretch with no pauses,
// and once the sender waits until every expected result has come back.
module testbench;

    // A run of about 480 transactions stays far inside this limit even with
    // heavy pausing on both sides. The limit only catches a hung unit.
    localparam int unsigned CYCLE_LIMIT = 100000;

    // Input transaction to output transaction is two register stages.
    localparam int unsigned DRAIN_CYCLES = 8;

    // ROM layer successor, indexed [address bits 3..2][current layer].
    localparam logic [0:3][0:3][1:0] LAYER_NEXT = {
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd2,
        2'd2, 2'd2, 2'd0, 2'd1,
        2'd1, 2'd0, 2'd1, 2'd0
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // Fields from bit 0: address[15:0], port_value[23:16], opcode_fetch[24],
    // dos_active[25], zero padding[31:26].
    logic [31:0] s_tdata;
    // Fields from bit 0: kind[1:0].
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // Fields from bit 0: slot0_is_ram[0], slot0_rom_page[4:1],
    // slot3_ram_page[10:5], screen_page[13:11], rom_layer[15:14], readback[23:16].
    logic [23:0] m_tdata;

    // These are the model's copies of the paging registers. They are updated
    // at the moment a transaction is accepted.
    logic [7:0] map_page_a;
    logic [7:0] map_page_b;
    logic       map_rom_sel;
    logic [1:0] map_layer;

    pmm_pkg::result_t expected_maps[$];
    bit               steady;
    int unsigned      fails;
    int unsigned      items_sent;
    int unsigned      results_seen;
    int unsigned      layer_steps;
    int unsigned      writes_dropped;
    int unsigned      ext_reads;
    int unsigned      cycle_count;

    paged_memory_mapper_with_rom_layers dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // This is the watchdog. A correct run finishes far inside the limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_maps.size());
            $display("FAIL paged_memory_mapper_with_rom_layers");
            $finish;
        end
    end

    // Applies one transaction to the model and returns the mapping that the
    // unit should report after it. A locked 7FFD write is counted and then
    // dropped. Only a data read of the layer window with paging enabled moves
    // the layer.
    function automatic pmm_pkg::result_t predict_mapping(input pmm_pkg::item_t it);
        pmm_pkg::result_t r;
        r.readback = pmm_pkg::READBACK_IDLE;
        case (it.kind)
            pmm_pkg::KIND_WR_7FFD: begin
                if (!map_page_a[pmm_pkg::LOCK_BIT]) begin
                    map_page_a  = it.port_value;
                    map_rom_sel = it.port_value[pmm_pkg::ROMSEL_BIT];
                end else begin
                    writes_dropped++;
                end
            end
            pmm_pkg::KIND_WR_1FFD: begin
                map_page_b = it.port_value;
            end
            pmm_pkg::KIND_MEM_RD: begin
                if (map_page_b[pmm_pkg::PAGING_BIT] && !it.opcode_fetch &&
                    (it.address & pmm_pkg::LAYER_ADDR_MASK) == pmm_pkg::LAYER_ADDR_MATCH) begin
                    map_layer = LAYER_NEXT[it.address[3:2]][map_layer];
                    layer_steps++;
                end
            end
            default: begin
                // The extension port answers on even addresses only.
                ext_reads++;
                if (!it.address[0])
                    r.readback = {2'b00, map_rom_sel, map_page_b[4], map_page_a[3:0]};
            end
        endcase
        r.slot0_is_ram = map_page_b[pmm_pkg::RAM0_BIT];
        if (r.slot0_is_ram)
            r.slot0_rom_page = 4'd0;
        else if (map_page_b[pmm_pkg::PAGING_BIT])
            r.slot0_rom_page = {map_layer, 2'b10};
        else
            r.slot0_rom_page = {map_layer, it.dos_active, map_rom_sel};
        r.slot3_ram_page = {map_page_b[7:6], map_page_b[4], map_page_a[2:0]};
        r.screen_page    = map_page_a[3] ? pmm_pkg::SCREEN_SHADOW : pmm_pkg::SCREEN_NORMAL;
        r.rom_layer      = map_layer;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // The scoreboard pairs each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        pmm_pkg::result_t got;
        pmm_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pmm_pkg::result_t'(m_tdata);
            if (expected_maps.size() == 0) begin
                $error("Result transaction arrived with no mapping expected");
                fails++;
            end else begin
                want = expected_maps.pop_front();
                results_seen++;
                check_field("slot0_is_ram",   32'(want.slot0_is_ram),   32'(got.slot0_is_ram));
                check_field("slot0_rom_page", 32'(want.slot0_rom_page),
                            32'(got.slot0_rom_page));
                check_field("slot3_ram_page", 32'(want.slot3_ram_page),
                            32'(got.slot3_ram_page));
                check_field("screen_page",    32'(want.screen_page),    32'(got.screen_page));
                check_field("rom_layer",      32'(want.rom_layer),      32'(got.rom_layer));
                check_field("readback",       32'(want.readback),       32'(got.readback));
            end
        end
    end

    // The result side stalls at random about 23 percent of the time, except during
    // the steady stretch.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= steady || ($urandom_range(99) >= 23);
        end
    end

    function automatic pmm_pkg::item_t make_access(input pmm_pkg::kind_t kind,
                                                   input logic [15:0] address,
                                                   input logic [7:0] value, input logic fetch,
                                                   input logic dos);
        pmm_pkg::item_t it;
        it.kind         = kind;
        it.address      = address;
        it.port_value   = value;
        it.opcode_fetch = fetch;
        it.dos_active   = dos;
        return it;
    endfunction

    // Random traffic is shaped towards useful cases. Most memory reads hit the
    // layer window, and most 1FFD writes enable paging so that the layer moves.
    // The lock bit is kept clear until the lock has been tested, because once
    // it is set only a reset would release it.
    function automatic pmm_pkg::item_t random_access(input bit allow_lock);
        pmm_pkg::item_t it;
        int unsigned    pick;
        pick            = $urandom_range(99);
        it.address      = 16'($urandom_range(16'hFFFF));
        it.port_value   = 8'($urandom_range(8'hFF));
        it.opcode_fetch = ($urandom_range(99) < 20);
        it.dos_active   = 1'($urandom_range(1));
        if (pick < 40) begin
            it.kind = pmm_pkg::KIND_MEM_RD;
            if ($urandom_range(99) < 70)
                it.address = pmm_pkg::LAYER_ADDR_MATCH | (16'($urandom_range(3)) << 2);
        end else if (pick < 60) begin
            it.kind = pmm_pkg::KIND_WR_7FFD;
            if (!allow_lock)
                it.port_value[pmm_pkg::LOCK_BIT] = 1'b0;
        end else if (pick < 78) begin
            it.kind = pmm_pkg::KIND_WR_1FFD;
            if ($urandom_range(99) < 75)
                it.port_value[pmm_pkg::PAGING_BIT] = 1'b1;
        end else begin
            it.kind = pmm_pkg::KIND_EXT_RD;
        end
        return it;
    endfunction

    // Presents one transaction, after a random pause unless the run is in its
    // steady stretch. The valid flag is left high, so back-to-back
    // transactions stream without a gap.
    task automatic send_access(input pmm_pkg::item_t it);
        while (!steady && $urandom_range(99) < 23) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, it.dos_active, it.opcode_fetch, it.port_value, it.address};
        s_tuser  <= it.kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_maps.push_back(predict_mapping(it));
        items_sent++;
    endtask

    // Withdraws the last transaction so that it is not taken twice, then waits
    // until every expected result has come back.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_maps.size() != 0)
            @(posedge aclk);
    endtask

    // This test covers the register extremes of both ports, the RAM mapping
    // of slot 0 and the disk-system ROM bit. Both parities of the extension
    // read are also covered.
    task automatic test_port_writes();
        send_access(make_access(pmm_pkg::KIND_EXT_RD,  16'h0000, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_WR_7FFD, 16'h0000, 8'hDF, 1'b0, 1'b1));
        send_access(make_access(pmm_pkg::KIND_EXT_RD,  16'h0000, 8'h00, 1'b0, 1'b1));
        send_access(make_access(pmm_pkg::KIND_EXT_RD,  16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_access(make_access(pmm_pkg::KIND_WR_1FFD, 16'hFFFF, 8'hFF, 1'b1, 1'b0));
        send_access(make_access(pmm_pkg::KIND_EXT_RD,  16'hFFFE, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_WR_1FFD, 16'h0000, 8'h00, 1'b0, 1'b1));
        send_access(make_access(pmm_pkg::KIND_WR_7FFD, 16'hFFFF, 8'h00, 1'b1, 1'b0));
    endtask

    // This test walks the layer through the table rows with paging enabled.
    // It then checks that an opcode fetch, a near-miss address and a read
    // with paging disabled all leave the layer where it is.
    task automatic test_layer_walk();
        send_access(make_access(pmm_pkg::KIND_WR_1FFD, 16'h0000, 8'h02, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h0104, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h010C, 8'h00, 1'b0, 1'b1));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h0108, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h0100, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h0104, 8'h00, 1'b1, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h0101, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'hFEFF, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_WR_1FFD, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_MEM_RD,  16'h0104, 8'h00, 1'b0, 1'b0));
    endtask

    // This test sends a lock write, whose value still loads. A later 7FFD
    // write is then dropped, while 1FFD stays writable.
    task automatic test_port_lock();
        send_access(make_access(pmm_pkg::KIND_WR_7FFD, 16'h0000, 8'h2A, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_WR_7FFD, 16'h0000, 8'h1D, 1'b0, 1'b0));
        send_access(make_access(pmm_pkg::KIND_EXT_RD,  16'h00FE, 8'h00, 1'b0, 1'b1));
        send_access(make_access(pmm_pkg::KIND_WR_1FFD, 16'h0000, 8'hD2, 1'b0, 1'b0));
    endtask

    // This test sends random traffic with the lock bit held clear. Part of it
    // runs with no pauses on either side, and partway through the sender waits
    // for the unit to drain completely.
    task automatic test_random_unlocked(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            steady = (i >= count / 3) && (i < count / 2);
            if (i == (3 * count) / 4)
                wait_results_drained();
            send_access(random_access(1'b0));
        end
        steady = 1'b0;
    endtask

    // This test sends random traffic with the lock bit free. After the lock
    // test, this exercises 7FFD writes that are dropped.
    task automatic test_random_locked(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_access(random_access(1'b1));
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = pmm_pkg::KIND_WR_7FFD;
        steady      = 1'b0;
        map_page_a  = '0;
        map_page_b  = '0;
        map_rom_sel = 1'b0;
        map_layer   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_port_writes();
        test_layer_walk();
        test_random_unlocked(400);
        test_port_lock();
        test_random_locked(50);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_results_drained();
        // Keep the clock running, so that any surplus result from the unit
        // still reaches the scoreboard.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_maps.size() != 0) begin
            $error("%0d expected results never arrived", expected_maps.size());
            fails++;
        end

        $display("Sent %0d bus transactions: %0d ROM layer steps, %0d extension reads,",
                 items_sent, layer_steps, ext_reads);
        $display("%0d locked port writes dropped; %0d results checked, %0d mismatches.",
                 writes_dropped, results_seen, fails);
        if (fails == 0) begin
            $display("PASS paged_memory_mapper_with_rom_layers");
        end else begin
            $display("FAIL paged_memory_mapper_with_rom_layers");
        end
        $finish;
    end

endmodule

>>> paged_memory_mapper_with_rom_layers.f
src/pmm_pkg.sv
src/pmm_in_stage.sv
src/pmm_core.sv
src/paged_memory_mapper_with_rom_layers.sv
src/pmm_checker.sv
verif/testbench.sv
